// ===== rtl/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg: shared types for the tournament branch predictor
// Item formats, command codes and the control structs that pass between
// the front and back halves of the core.
// ----------------------------------------------------------------------------
package tbp_pkg;

   // default table geometry
   localparam int GHIST_BITS_DEF    = 9;
   localparam int LHIST_BITS_DEF    = 10;
   localparam int PC_INDEX_BITS_DEF = 10;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      CMD_PREDICT = 1'b0,
      CMD_TRAIN   = 1'b1
   } tbp_cmd_type;

   typedef struct packed {
      logic        cmd;
      logic [31:0] pc;
      logic        outcome;
   } tbp_req_type;

   typedef struct packed {
      logic prediction;
      logic local_guess;
      logic global_guess;
   } tbp_rsp_type;

   // head of the queue as seen by the back half
   typedef struct packed {
      logic valid;
      logic train;
      logic outcome;
   } tbp_op_type;

   // back half status toward the front half
   typedef struct packed {
      logic pop;
      logic clearing;
   } tbp_stat_type;

endpackage

// ===== rtl/tbp_front.sv =====
// ----------------------------------------------------------------------------
// tbp_front: item intake and queue
// Accepts items, decodes the command, keeps the pc slot and buffers the item
// in a short queue until the back half pops it.
// ----------------------------------------------------------------------------
module tbp_front #(
   parameter int PC_INDEX_BITS = tbp_pkg::PC_INDEX_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  tbp_pkg::tbp_req_type      req_item,
   input  tbp_pkg::tbp_stat_type     stat,
   output logic                      busy,
   output tbp_pkg::tbp_op_type       q_op,
   output logic [PC_INDEX_BITS-1:0]  q_slot
);
   import tbp_pkg::*;

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [QW-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [QW:0]              count_ff, count_in;
   logic                     entry_train_ff   [QUEUE_DEPTH];
   logic                     entry_outcome_ff [QUEUE_DEPTH];
   logic [PC_INDEX_BITS-1:0] entry_slot_ff    [QUEUE_DEPTH];
   logic                     push;
   logic                     pop;
   logic                     full;

   assign full = (count_ff == (QW+1)'(QUEUE_DEPTH));
   assign busy = full || stat.clearing;
   assign push = start && !busy;
   assign pop  = stat.pop && q_op.valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // classify and store the item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_train_ff[wr_ptr_ff]   <= (req_item.cmd == CMD_TRAIN);
         entry_outcome_ff[wr_ptr_ff] <= req_item.outcome;
         entry_slot_ff[wr_ptr_ff]    <= req_item.pc[PC_INDEX_BITS-1:0];
      end
   end

   assign q_op.valid   = (count_ff != '0);
   assign q_op.train   = entry_train_ff[rd_ptr_ff];
   assign q_op.outcome = entry_outcome_ff[rd_ptr_ff];
   assign q_slot       = entry_slot_ff[rd_ptr_ff];

endmodule

// ===== rtl/tbp_back.sv =====
// ----------------------------------------------------------------------------
// tbp_back: table lookup and update engine
// Holds the history and counter tables, clears them after reset, and runs
// each queued item through read, counter read and execute steps.
// ----------------------------------------------------------------------------
module tbp_back #(
   parameter int GHIST_BITS    = tbp_pkg::GHIST_BITS_DEF,
   parameter int LHIST_BITS    = tbp_pkg::LHIST_BITS_DEF,
   parameter int PC_INDEX_BITS = tbp_pkg::PC_INDEX_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tbp_pkg::tbp_op_type       q_op,
   input  logic [PC_INDEX_BITS-1:0]  q_slot,
   output tbp_pkg::tbp_stat_type     stat,
   output logic                      rsp_strobe,
   output tbp_pkg::tbp_rsp_type      rsp_item
);
   import tbp_pkg::*;

   localparam int PC_DEPTH = 1 << PC_INDEX_BITS;
   localparam int LC_DEPTH = 1 << LHIST_BITS;
   localparam int GC_DEPTH = 1 << GHIST_BITS;
   localparam int MAX_LP   = (LHIST_BITS > PC_INDEX_BITS) ? LHIST_BITS : PC_INDEX_BITS;
   localparam int CLR_BITS = (GHIST_BITS > MAX_LP) ? GHIST_BITS : MAX_LP;
   localparam logic [1:0] CTR_WEAK_NT = 2'd1;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_READ_LC,
      S_EXEC
   } state_type;

   function automatic logic [1:0] ctr_move(input logic [1:0] c, input logic up);
      if (up) begin
         return (c == 2'd3) ? c : c + 2'd1;
      end
      return (c == 2'd0) ? c : c - 2'd1;
   endfunction

   // tables
   logic [LHIST_BITS-1:0] lht_mem [PC_DEPTH];
   logic [1:0]            lc_mem  [LC_DEPTH];
   logic [1:0]            gc_mem  [GC_DEPTH];
   logic [1:0]            ch_mem  [GC_DEPTH];

   state_type                state_ff;
   logic [CLR_BITS-1:0]      clr_ptr_ff;
   logic [PC_INDEX_BITS-1:0] slot_ff;
   logic                     train_ff;
   logic                     outcome_ff;
   logic [LHIST_BITS-1:0]    lidx_ff;
   logic [GHIST_BITS-1:0]    ghist_ff, ghist_in;
   logic                     latch_l_ff;
   logic                     latch_g_ff;
   logic                     rsp_strobe_ff;
   tbp_rsp_type              rsp_item_ff;

   logic [LHIST_BITS-1:0]    lht_rd_ff;
   logic [1:0]               lc_rd_ff;
   logic [1:0]               gc_rd_ff;
   logic [1:0]               ch_rd_ff;

   logic                     clearing;
   logic                     exec_train;
   logic                     lht_we, lc_we, gc_we, ch_we;
   logic [PC_INDEX_BITS-1:0] lht_waddr;
   logic [LHIST_BITS-1:0]    lht_wdata;
   logic [LHIST_BITS-1:0]    lc_waddr;
   logic [1:0]               lc_wdata;
   logic [GHIST_BITS-1:0]    gc_waddr;
   logic [1:0]               gc_wdata;
   logic [1:0]               ch_wdata;
   logic [LHIST_BITS:0]      lhist_shift;
   logic [GHIST_BITS:0]      ghist_shift;
   logic                     lg, gg, pick;

   assign clearing   = (state_ff == S_CLEAR);
   assign exec_train = (state_ff == S_EXEC) && train_ff;

   assign stat.clearing = clearing;
   assign stat.pop      = (state_ff == S_IDLE) && q_op.valid;

   assign lhist_shift = {lidx_ff, outcome_ff};
   assign ghist_shift = {ghist_ff, outcome_ff};
   assign ghist_in    = ghist_shift[GHIST_BITS-1:0];

   assign lg   = lc_rd_ff[1];
   assign gg   = gc_rd_ff[1];
   assign pick = ch_rd_ff[1] ? lg : gg;

   always_comb begin
      lht_we    = clearing || exec_train;
      lc_we     = clearing || exec_train;
      gc_we     = clearing || exec_train;
      ch_we     = clearing || (exec_train && (latch_l_ff != latch_g_ff));
      lht_waddr = slot_ff;
      lht_wdata = lhist_shift[LHIST_BITS-1:0];
      lc_waddr  = lidx_ff;
      lc_wdata  = ctr_move(lc_rd_ff, outcome_ff);
      gc_waddr  = ghist_ff;
      gc_wdata  = ctr_move(gc_rd_ff, outcome_ff);
      ch_wdata  = ctr_move(ch_rd_ff, latch_l_ff == outcome_ff);
      if (clearing) begin
         lht_waddr = clr_ptr_ff[PC_INDEX_BITS-1:0];
         lht_wdata = '0;
         lc_waddr  = clr_ptr_ff[LHIST_BITS-1:0];
         lc_wdata  = CTR_WEAK_NT;
         gc_waddr  = clr_ptr_ff[GHIST_BITS-1:0];
         gc_wdata  = CTR_WEAK_NT;
         ch_wdata  = CTR_WEAK_NT;
      end
   end

   always_ff @(posedge clock) begin
      if (lht_we) begin
         lht_mem[lht_waddr] <= lht_wdata;
      end
      lht_rd_ff <= lht_mem[q_slot];
   end

   always_ff @(posedge clock) begin
      if (lc_we) begin
         lc_mem[lc_waddr] <= lc_wdata;
      end
      lc_rd_ff <= lc_mem[lht_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (gc_we) begin
         gc_mem[gc_waddr] <= gc_wdata;
      end
      gc_rd_ff <= gc_mem[ghist_ff];
   end

   always_ff @(posedge clock) begin
      if (ch_we) begin
         ch_mem[gc_waddr] <= ch_wdata;
      end
      ch_rd_ff <= ch_mem[ghist_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ptr_ff    <= '0;
         ghist_ff      <= '0;
         latch_l_ff    <= 1'b0;
         latch_g_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ptr_ff <= clr_ptr_ff + 1'b1;
               if (clr_ptr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               // take the queue head; table reads start this cycle
               if (q_op.valid) begin
                  slot_ff    <= q_slot;
                  train_ff   <= q_op.train;
                  outcome_ff <= q_op.outcome;
                  state_ff   <= S_READ_LC;
               end
            end
            S_READ_LC: begin
               lidx_ff  <= lht_rd_ff;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (train_ff) begin
                  ghist_ff <= ghist_in;
               end else begin
                  latch_l_ff               <= lg;
                  latch_g_ff               <= gg;
                  rsp_strobe_ff            <= 1'b1;
                  rsp_item_ff.prediction   <= pick;
                  rsp_item_ff.local_guess  <= lg;
                  rsp_item_ff.global_guess <= gg;
               end
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// ===== rtl/tournament_branch_predictor_core.sv =====
// With an empty queue, a predict item is written into the queue, popped by the back
// engine in S_IDLE and passed through S_READ_LC and S_EXEC, which registers rsp_strobe.
// Items: the back engine runs each one through its table read, counter read and
// execute steps before it takes the next; two items may queue.
// Reset: synchronous; afterwards busy stays high for a clearing pass over
// 2^max(GHIST_BITS, LHIST_BITS, PC_INDEX_BITS) table addresses (1024 by default).
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core: tournament branch predictor
// Local and global two-bit counter predictors with a chooser table, split
// into an intake front with a short queue and a table engine back.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core #(
   parameter int GHIST_BITS    = tbp_pkg::GHIST_BITS_DEF,
   parameter int LHIST_BITS    = tbp_pkg::LHIST_BITS_DEF,
   parameter int PC_INDEX_BITS = tbp_pkg::PC_INDEX_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tbp_pkg::tbp_req_type req_item,
   output logic                 rsp_strobe,
   output tbp_pkg::tbp_rsp_type rsp_item
);
   import tbp_pkg::*;

   tbp_op_type               q_op;
   logic [PC_INDEX_BITS-1:0] q_slot;
   tbp_stat_type             stat;

   // front: accept the item, decode the command, hold it in the queue
   tbp_front #(
      .PC_INDEX_BITS (PC_INDEX_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .stat     (stat),
      .busy     (busy),
      .q_op     (q_op),
      .q_slot   (q_slot)
   );

   // back: clear the tables after reset, then look up or train per item
   tbp_back #(
      .GHIST_BITS    (GHIST_BITS),
      .LHIST_BITS    (LHIST_BITS),
      .PC_INDEX_BITS (PC_INDEX_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_op       (q_op),
      .q_slot     (q_slot),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

`ifndef SYNTHESIS
   // each item passes the S_IDLE, S_READ_LC and S_EXEC states of the back engine
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobes on consecutive cycles");

   // the chosen prediction is one of the two component guesses
   a_pick_is_guess: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.prediction == rsp_item.local_guess ||
                      rsp_item.prediction == rsp_item.global_guess))
      else $error("prediction matches neither component guess");

   // tables are being cleared right after reset, so no item may enter
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (busy && stat.clearing))
      else $error("item intake open before table clearing");

   // no result while the tables are being cleared
   a_quiet_while_clearing: assert property (@(posedge clock) disable iff (reset)
      stat.clearing |-> !rsp_strobe)
      else $error("result during table clearing");
`endif

endmodule
